/* rtl/core/mcg_pkg.sv */
// ----------------------------------------------------------------------------
// mcg_pkg
// shared types, constants and calendar tables of the month calendar grid
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int SheetEntries = 44;
  localparam int IdxW         = $clog2(SheetEntries);

  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int WsW    = 3;
  localparam int LeadW  = 3;
  localparam int LenW   = 5;
  localparam int EntryW = 14;

  localparam logic [MonthW-1:0] MonthMin      = MonthW'(1);
  localparam logic [MonthW-1:0] MonthMax      = MonthW'(12);
  localparam logic [MonthW-1:0] MonthFallback = MonthW'(1);
  localparam logic [YearW-1:0]  YearMin       = YearW'(1582);
  localparam logic [YearW-1:0]  YearMax       = YearW'(9999);
  localparam logic [YearW-1:0]  YearFallback  = YearW'(1970);

  // floor(x / 25) = (x * Recip25) >> Recip25Shift for x below 2^12
  localparam int unsigned Recip25      = 5243;
  localparam int          Recip25Shift = 17;
  // floor(x / 7) = (x * Recip7) >> Recip7Shift for x below 2^14
  localparam int unsigned Recip7       = 37450;
  localparam int          Recip7Shift  = 18;

  typedef enum logic {
    CFG_DEFAULT_MONTH = 1'b0,
    CFG_DEFAULT_YEAR  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    EMIT_IDLE,
    EMIT_RUN
  } emit_state_e;

  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic              full;
    logic [LeadW-1:0]  lead;
    logic [LenW-1:0]   len;
    logic [LenW-1:0]   prev_len;
  } job_t;

  function automatic logic [2:0] month_key(input logic [MonthW-1:0] m);
    logic [2:0] k;
    unique case (m)
      4'd1:    k = 3'd0;
      4'd2:    k = 3'd3;
      4'd3:    k = 3'd2;
      4'd4:    k = 3'd5;
      4'd5:    k = 3'd0;
      4'd6:    k = 3'd3;
      4'd7:    k = 3'd5;
      4'd8:    k = 3'd1;
      4'd9:    k = 3'd4;
      4'd10:   k = 3'd6;
      4'd11:   k = 3'd2;
      4'd12:   k = 3'd4;
      default: k = 3'd0;
    endcase
    return k;
  endfunction

  function automatic logic [LenW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [LenW-1:0] d;
    unique case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

/* rtl/core/month_calendar_grid.sv */
// ----------------------------------------------------------------------------
// month_calendar_grid
// perpetual gregorian calendar: one request in, one month sheet out
// ----------------------------------------------------------------------------
// A request transfer on the s_axis channel names month, year, week start
// (tdata) and the full-grid flag (tuser). The m_axis channel then returns a
// sheet of 44 entries, one transfer each: month, year, then 42 grid cells in
// row order; tlast marks the final entry.
// A request passes through the six-stage calculation pipeline and the
// sequencer load before its first entry is shown; the sheet then leaves at
// one entry per cycle while m_axis_tready stays high, and the next request
// is loaded only as the last entry of a sheet enters the output register.
// Requests queue in the pipeline while a sheet is in progress and follow without a gap.
// The cfg channel writes default month (index 0) and default year (index 1)
// and is always ready; write it only while the block is idle.
// Reset empties the pipeline and sequencer and loads month 1, year 1970.
// When m_axis_tready is low the shown entry holds; once a job waits in the
// last pipeline stage the whole pipeline stops and s_axis_tready drops;
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
module month_calendar_grid import mcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // month[3:0], year[17:4], week_start[20:18]
  input  logic        s_axis_tuser,   // full_grid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // entry_value[13:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [13:0] cfg_data_i
);

  logic [MonthW-1:0] dflt_month_q;
  logic [YearW-1:0]  dflt_year_q;
  logic              job_valid, job_ready;
  job_t              job;
  logic [EntryW-1:0] entry_value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_month_q <= MonthW'(1);
      dflt_year_q  <= YearFallback;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DEFAULT_MONTH: dflt_month_q <= cfg_data_i[MonthW-1:0];
        CFG_DEFAULT_YEAR:  dflt_year_q  <= cfg_data_i[YearW-1:0];
        default:           dflt_month_q <= dflt_month_q;
      endcase
    end
  end

  mcg_calc u_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .month_i      (s_axis_tdata[3:0]),
    .year_i       (s_axis_tdata[17:4]),
    .full_i       (s_axis_tuser),
    .week_start_i (s_axis_tdata[20:18]),
    .dflt_month_i (dflt_month_q),
    .dflt_year_i  (dflt_year_q),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_o        (job)
  );

  mcg_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (entry_value),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, entry_value};

endmodule

/* rtl/core/mcg_calc.sv */
// ----------------------------------------------------------------------------
// mcg_calc
// six-stage pipeline: range repair, leap rule, weekday of day one, week shift
// ----------------------------------------------------------------------------
module mcg_calc import mcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MonthW-1:0] month_i,
  input  logic [YearW-1:0]  year_i,
  input  logic              full_i,
  input  logic [WsW-1:0]    week_start_i,
  input  logic [MonthW-1:0] dflt_month_i,
  input  logic [YearW-1:0]  dflt_year_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output job_t              job_o
);

  localparam int PW = 25;
  localparam int QW = 7;
  localparam int SW = 14;
  localparam int MW = 30;
  localparam int Q7W = 11;

  logic [5:0] v_q, v_d;
  logic       en;

  // stage 1
  logic [MonthW-1:0] m1_q, m1_d;
  logic [YearW-1:0]  y1_q, y1_d;
  logic              full1_q;
  logic [WsW-1:0]    ws1_q;
  // stage 2
  logic [MonthW-1:0] m2_q;
  logic [YearW-1:0]  y2_q, yy2_q, yy;
  logic              full2_q;
  logic [WsW-1:0]    ws2_q;
  logic [PW-1:0]     p100_q, p100_d, p400_q, p400_d, py4_q, py4_d, py16_q, py16_d;
  // stage 3
  logic [MonthW-1:0] m3_q;
  logic [YearW-1:0]  y3_q, yy3_q;
  logic              full3_q, leap3_q, leap3_d;
  logic [WsW-1:0]    ws3_q;
  logic [QW-1:0]     q100_3_q, q400_3_q, qy4, qy16;
  logic [11:0]       y4c;
  logic [9:0]        y16c;
  // stage 4
  logic [MonthW-1:0] m4_q;
  logic [YearW-1:0]  y4_q;
  logic              full4_q;
  logic [WsW-1:0]    ws4_q;
  logic [SW-1:0]     sum4_q, sum4_d;
  logic [LenW-1:0]   len4_q, len4_d, prev4_q, prev4_d;
  // stage 5
  logic [MonthW-1:0] m5_q;
  logic [YearW-1:0]  y5_q;
  logic              full5_q;
  logic [WsW-1:0]    ws5_q;
  logic [SW-1:0]     sum5_q;
  logic [MW-1:0]     prod5_q, prod5_d;
  logic [LenW-1:0]   len5_q, prev5_q;
  // stage 6
  job_t              job_q, job_d;
  logic [Q7W-1:0]    q7;
  logic [2:0]        wd;
  logic [3:0]        shifted;

  assign en          = !v_q[5] || job_ready_i;
  assign in_ready_o  = en;
  assign job_valid_o = v_q[5];
  assign job_o       = job_q;
  assign v_d         = {v_q[4:0], in_valid_i};

  // stage 1: range repair
  always_comb begin
    if (month_i >= MonthMin && month_i <= MonthMax) begin
      m1_d = month_i;
    end else if (dflt_month_i >= MonthMin && dflt_month_i <= MonthMax) begin
      m1_d = dflt_month_i;
    end else begin
      m1_d = MonthFallback;
    end
    if (year_i >= YearMin && year_i <= YearMax) begin
      y1_d = year_i;
    end else if (dflt_year_i >= YearMin && dflt_year_i <= YearMax) begin
      y1_d = dflt_year_i;
    end else begin
      y1_d = YearFallback;
    end
  end

  // stage 2: reciprocal products for the divisions by 100 and 400
  always_comb begin
    yy      = (m1_q < MonthW'(3)) ? y1_q - YearW'(1) : y1_q;
    p100_d  = PW'(yy[YearW-1:2]) * PW'(Recip25);
    p400_d  = PW'(yy[YearW-1:4]) * PW'(Recip25);
    py4_d   = PW'(y1_q[YearW-1:2]) * PW'(Recip25);
    py16_d  = PW'(y1_q[YearW-1:4]) * PW'(Recip25);
  end

  // stage 3: quotients and leap rule
  always_comb begin
    qy4     = py4_q[Recip25Shift +: QW];
    qy16    = py16_q[Recip25Shift +: QW];
    y4c     = 12'(qy4) * 12'd25;
    y16c    = 10'(qy16) * 10'd25;
    leap3_d = (y2_q[1:0] == 2'b00) &&
              ((y2_q[YearW-1:2] != y4c) ||
               ((y2_q[3:0] == 4'b0000) && (y2_q[YearW-1:4] == y16c)));
  end

  // stage 4: weekday sum and month lengths
  always_comb begin
    sum4_d  = yy3_q + SW'(yy3_q[YearW-1:2]) - SW'(q100_3_q) + SW'(q400_3_q)
              + SW'(month_key(m3_q)) + SW'(1);
    len4_d  = month_days(m3_q, leap3_q);
    prev4_d = (m3_q == MonthMin) ? LenW'(31) : month_days(m3_q - MonthW'(1), leap3_q);
  end

  // stage 5: reciprocal product for the modulo 7
  assign prod5_d = MW'(sum4_q) * MW'(Recip7);

  // stage 6: weekday and week-start shift
  always_comb begin
    q7      = prod5_q[Recip7Shift +: Q7W];
    wd      = 3'(sum5_q - SW'(q7) * SW'(7));
    shifted = {1'b0, wd} + 4'd7 - {1'b0, ws5_q};
    job_d.month    = m5_q;
    job_d.year     = y5_q;
    job_d.full     = full5_q;
    job_d.len      = len5_q;
    job_d.prev_len = prev5_q;
    if (ws5_q >= WsW'(1) && ws5_q <= WsW'(6)) begin
      job_d.lead = (shifted >= 4'd7) ? 3'(shifted - 4'd7) : shifted[2:0];
    end else begin
      job_d.lead = wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q     <= m1_d;
      y1_q     <= y1_d;
      full1_q  <= full_i;
      ws1_q    <= week_start_i;

      m2_q     <= m1_q;
      y2_q     <= y1_q;
      yy2_q    <= yy;
      full2_q  <= full1_q;
      ws2_q    <= ws1_q;
      p100_q   <= p100_d;
      p400_q   <= p400_d;
      py4_q    <= py4_d;
      py16_q   <= py16_d;

      m3_q     <= m2_q;
      y3_q     <= y2_q;
      yy3_q    <= yy2_q;
      full3_q  <= full2_q;
      ws3_q    <= ws2_q;
      q100_3_q <= p100_q[Recip25Shift +: QW];
      q400_3_q <= p400_q[Recip25Shift +: QW];
      leap3_q  <= leap3_d;

      m4_q     <= m3_q;
      y4_q     <= y3_q;
      full4_q  <= full3_q;
      ws4_q    <= ws3_q;
      sum4_q   <= sum4_d;
      len4_q   <= len4_d;
      prev4_q  <= prev4_d;

      m5_q     <= m4_q;
      y5_q     <= y4_q;
      full5_q  <= full4_q;
      ws5_q    <= ws4_q;
      sum5_q   <= sum4_q;
      prod5_q  <= prod5_d;
      len5_q   <= len4_q;
      prev5_q  <= prev4_q;

      job_q    <= job_d;
    end
  end

`ifndef SYNTHESIS
  a_lead_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> job_q.lead <= LeadW'(6))
    else $error("leading offset out of range");
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> (job_q.len >= LenW'(28) && job_q.len <= LenW'(31)))
    else $error("month length out of range");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] && !job_ready_i |=> v_q[5] && $stable(job_q))
    else $error("stalled job changed");
`endif

endmodule

/* rtl/core/mcg_emit.sv */
// ----------------------------------------------------------------------------
// mcg_emit
// sheet sequencer: walks the entries of one job into a registered output
// ----------------------------------------------------------------------------
module mcg_emit import mcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  job_t              job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [EntryW-1:0] out_value_o,
  output logic              out_last_o
);

  localparam int CW = IdxW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SheetEntries - 1);

  emit_state_e       state_q, state_d;
  job_t              job_q;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              out_valid_q, out_valid_d, out_last_q;
  logic [EntryW-1:0] out_value_q, entry;
  logic              out_free, adv, at_last, load;
  logic [CW-1:0]     slot, lead_x, len_x, day, lead_day;

  assign out_free = !out_valid_q || out_ready_i;
  assign at_last  = idx_q == LastIdx;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EMIT_IDLE: if (job_valid_i) state_d = EMIT_RUN;
      EMIT_RUN:  if (out_free && at_last && !job_valid_i) state_d = EMIT_IDLE;
      default:   state_d = EMIT_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    adv         = 1'b0;
    job_ready_o = 1'b0;
    unique case (state_q)
      EMIT_IDLE: job_ready_o = 1'b1;
      EMIT_RUN: begin
        adv         = out_free;
        job_ready_o = out_free && at_last;
      end
      default: job_ready_o = 1'b0;
    endcase
  end

  assign load = job_valid_i && job_ready_o;

  always_comb begin
    if (load) begin
      idx_d = '0;
    end else if (adv) begin
      idx_d = idx_q + IdxW'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  // entry value
  always_comb begin
    slot     = CW'(idx_q) - CW'(2);
    lead_x   = CW'(job_q.lead);
    len_x    = CW'(job_q.len);
    day      = slot - lead_x + CW'(1);
    lead_day = CW'(job_q.prev_len) - lead_x + CW'(1) + slot;
    if (idx_q == IdxW'(0)) begin
      entry = EntryW'(job_q.month);
    end else if (idx_q == IdxW'(1)) begin
      entry = job_q.year;
    end else if (slot < lead_x) begin
      entry = job_q.full ? EntryW'(lead_day) : '0;
    end else if (day <= len_x) begin
      entry = EntryW'(day);
    end else begin
      entry = job_q.full ? EntryW'(day - len_x) : '0;
    end
  end

  assign out_valid_d = adv || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EMIT_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (adv) begin
      out_value_q <= entry;
      out_last_q  <= at_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (state_q == EMIT_IDLE) || (adv && at_last))
    else $error("job loaded while a sheet is in progress");
  a_first_is_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && idx_q == IdxW'(0) |=> out_value_q == EntryW'(job_q.month))
    else $error("first entry is not the month");
  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_last_q == $past(at_last))
    else $error("last entry flag misplaced");
`endif

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the month calendar sheet generator
// ----------------------------------------------------------------------------
// Requests go in on s_axis from a queue of pending requests, and the bench
// works out each 44-entry sheet on its own: it repairs out-of-range months
// and years from its copy of the default registers, finds the weekday of
// day 1 and the month length, and fills the leading, day and trailing
// cells. Entries leaving on m_axis are checked in order against the
// expected sheets. Both sides idle at random. The default registers are
// rewritten between phases (in range, at the extremes and out of range),
// only once every expected entry has arrived.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top import mcg_pkg::*; ();

  localparam int StallLimit = 3000;

  typedef struct packed {
    logic [3:0]  month;
    logic [13:0] year;
    logic        full;
    logic [2:0]  ws;
  } cal_req_t;

  typedef struct packed {
    logic [13:0] value;
    logic        last;
  } sheet_entry_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // month[3:0], year[17:4], week_start[20:18]
  logic        s_axis_tuser = 1'b0; // full_grid
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // entry_value[13:0]
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_reg_e    cfg_index_i = CFG_DEFAULT_MONTH;
  logic [13:0] cfg_data_i = '0;

  month_calendar_grid dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  int unsigned weekday_key [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
  int unsigned month_len_tab [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // bench copy of the default registers
  logic [3:0]  dflt_month = 4'd1;
  logic [13:0] dflt_year  = 14'd1970;

  cal_req_t     pending_reqs [$];
  sheet_entry_t sheet_q [$];
  cal_req_t     cur_req;
  int           issued = 0;
  int           accepted = 0;
  int           cfg_cnt = 0;
  int           err_cnt = 0;
  int           quiet = 0;
  int           src_gap = 0;
  int           sink_gap = 0;
  bit           src_idle = 1'b1;
  bit           sink_idle = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned days_of(int unsigned m, int unsigned y);
    if (m == 2 && (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0))) return 29;
    return month_len_tab[m - 1];
  endfunction

  // expected sheet for one request under the current defaults
  function automatic void predict_sheet(cal_req_t r);
    int unsigned  m, y, yy, lead, len, prev_len, pos, dd;
    int unsigned  cells [SheetEntries];
    sheet_entry_t e;
    m = r.month;
    y = r.year;
    if (m < 1 || m > 12) begin
      m = dflt_month;
      if (m < 1 || m > 12) m = 1;
    end
    if (y < 1582 || y > 9999) begin
      y = dflt_year;
      if (y < 1582 || y > 9999) y = 1970;
    end
    len = days_of(m, y);
    yy = (m < 3) ? y - 1 : y;
    lead = (yy + yy / 4 - yy / 100 + yy / 400 + weekday_key[m - 1] + 1) % 7;
    if (r.ws >= 1 && r.ws <= 6) lead = (lead + 7 - r.ws) % 7;
    foreach (cells[i]) cells[i] = 0;
    cells[0] = m;
    cells[1] = y;
    if (r.full && lead > 0) begin
      prev_len = (m == 1) ? 31 : days_of(m - 1, y);
      for (int i = 0; i < lead; i++) begin
        if (2 + i < SheetEntries) cells[2 + i] = prev_len - (lead - 1) + i;
      end
    end
    pos = 2 + lead;
    for (dd = 1; dd <= len; dd++) begin
      if (pos < SheetEntries) cells[pos] = dd;
      pos++;
    end
    if (r.full) begin
      dd = 1;
      while (pos < SheetEntries) begin
        cells[pos] = dd;
        dd++;
        pos++;
      end
    end
    for (int i = 0; i < SheetEntries; i++) begin
      e.value = cells[i][13:0];
      e.last  = (i == SheetEntries - 1);
      sheet_q.push_back(e);
    end
  endfunction

  function automatic cal_req_t rand_req();
    cal_req_t r;
    int       k;
    k = $urandom_range(0, 99);
    r.month = (k < 75) ? 4'($urandom_range(1, 12)) : 4'($urandom_range(0, 15));
    k = $urandom_range(0, 99);
    if (k < 65) begin
      r.year = 14'($urandom_range(1582, 9999));
    end else if (k < 75) begin
      case ($urandom_range(0, 3))
        0: r.year = 14'(1582 + $urandom_range(0, 3));
        1: r.year = 14'(9996 + $urandom_range(0, 3));
        2: r.year = 14'(1578 + $urandom_range(0, 3));
        default: r.year = 14'(10000 + $urandom_range(0, 3));
      endcase
    end else if (k < 88) begin
      r.year = 14'($urandom_range(0, 16383));
    end else begin
      r.year = $urandom_range(0, 1) ? 14'($urandom_range(0, 1581))
                                    : 14'($urandom_range(10000, 16383));
    end
    r.full = 1'($urandom_range(0, 1));
    r.ws   = 3'($urandom_range(0, 7));
    return r;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [13:0] val);
    int start;
    @(negedge clk_i);
    start = cfg_cnt;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (cfg_cnt == start);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || issued != accepted || sheet_q.size() > 0)
      @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (issued == accepted) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        s_axis_tdata  <= {3'b000, cur_req.ws, cur_req.year, cur_req.month};
        s_axis_tuser  <= cur_req.full;
        s_axis_tvalid <= 1'b1;
        issued++;
        if (src_idle) src_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sheet receiver back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (sink_idle && $urandom_range(0, 3) == 0) sink_gap = pick_gap();
    end
  end

  // transfer monitor, checker and watchdog
  always @(posedge clk_i) begin : mon
    bit           moved;
    sheet_entry_t exp_e;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_DEFAULT_MONTH) dflt_month = cfg_data_i[3:0];
        else dflt_year = cfg_data_i;
        cfg_cnt++;
        moved = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_sheet(cur_req);
        accepted++;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (sheet_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected entry: expected none, actual value %0d last %0b",
                   $time, m_axis_tdata[13:0], m_axis_tlast);
        end else begin
          exp_e = sheet_q.pop_front();
          if (m_axis_tdata[13:0] !== exp_e.value) begin
            err_cnt++;
            $display("%0t: entry value mismatch: expected %0d, actual %0d",
                     $time, exp_e.value, m_axis_tdata[13:0]);
          end
          if (m_axis_tlast !== exp_e.last) begin
            err_cnt++;
            $display("%0t: tlast mismatch: expected %0b, actual %0b",
                     $time, exp_e.last, m_axis_tlast);
          end
        end
      end
      if (moved) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= StallLimit) begin
          $display("%0t: timeout, no transfer for %0d cycles", $time, quiet);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    cal_req_t directed [$];
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: field extremes, leap rules, week starts, neighbor months
    directed = '{
      '{4'd1,  14'd1970,  1'b0, 3'd0},
      '{4'd1,  14'd1582,  1'b1, 3'd0},
      '{4'd12, 14'd9999,  1'b1, 3'd6},
      '{4'd2,  14'd2000,  1'b1, 3'd1},
      '{4'd2,  14'd1900,  1'b1, 3'd2},
      '{4'd2,  14'd2024,  1'b0, 3'd3},
      '{4'd3,  14'd2024,  1'b1, 3'd4},
      '{4'd3,  14'd2023,  1'b1, 3'd5},
      '{4'd0,  14'd2020,  1'b1, 3'd7},
      '{4'd13, 14'd1999,  1'b1, 3'd0},
      '{4'd15, 14'd16383, 1'b1, 3'd6},
      '{4'd6,  14'd0,     1'b1, 3'd1},
      '{4'd6,  14'd1581,  1'b0, 3'd2},
      '{4'd6,  14'd10000, 1'b1, 3'd3},
      '{4'd7,  14'd16383, 1'b1, 3'd7},
      '{4'd8,  14'd9999,  1'b0, 3'd5},
      '{4'd11, 14'd1582,  1'b1, 3'd4},
      '{4'd10, 14'd2015,  1'b1, 3'd0},
      '{4'd5,  14'd2011,  1'b1, 3'd6},
      '{4'd9,  14'd4000,  1'b1, 3'd1},
      '{4'd4,  14'd8191,  1'b1, 3'd3},
      '{4'd14, 14'd5461,  1'b0, 3'd6}
    };
    foreach (directed[i]) pending_reqs.push_back(directed[i]);
    drain();

    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_DEFAULT_MONTH, 14'd12);
          write_reg(CFG_DEFAULT_YEAR, 14'd9999);
        end
        2: begin
          write_reg(CFG_DEFAULT_MONTH, 14'd0);
          write_reg(CFG_DEFAULT_YEAR, 14'd0);
        end
        3: begin
          write_reg(CFG_DEFAULT_MONTH, 14'd15);
          write_reg(CFG_DEFAULT_YEAR, 14'd16383);
        end
        4: begin
          write_reg(CFG_DEFAULT_MONTH, 14'd1);
          write_reg(CFG_DEFAULT_YEAR, 14'd1582);
        end
        5: begin
          write_reg(CFG_DEFAULT_MONTH, 14'd13);
          write_reg(CFG_DEFAULT_YEAR, 14'd1581);
        end
        default: begin
          write_reg(CFG_DEFAULT_MONTH, 14'($urandom_range(0, 15)));
          write_reg(CFG_DEFAULT_YEAR, $urandom_range(0, 4) != 0
                                      ? 14'($urandom_range(1582, 9999))
                                      : 14'($urandom_range(0, 16383)));
        end
      endcase
      // some phases run without gaps on one or both sides
      src_idle  = !(ph == 3 || ph == 6);
      sink_idle = !(ph == 3 || ph == 5);
      repeat (37) pending_reqs.push_back(rand_req());
      drain();
    end

    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
